FILE: hdl/lsb_pkg.sv
// ----------------------------------------------------------------------------
// lsb_pkg
// Shared widths, register codes and word types of the seam blend pipeline.
// ----------------------------------------------------------------------------
package lsb_pkg;

  localparam int COLUMN_BITS = 12;
  localparam int WIDTH_BITS  = COLUMN_BITS + 1;
  localparam int CH_BITS     = 8;
  localparam int SUM_BITS    = CH_BITS + WIDTH_BITS;
  localparam int CELL_COUNT  = CH_BITS;
  localparam int CH_COUNT    = 3;

  localparam logic [COLUMN_BITS-1:0] START_RESET = '0;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET = WIDTH_BITS'(4096);

  typedef enum logic [0:0] {
    CFG_OVERLAP_START = 1'b0,
    CFG_IMAGE_WIDTH   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_BITS-1:0]     base_blue;
    logic [CH_BITS-1:0]     base_green;
    logic [CH_BITS-1:0]     base_red;
    logic [CH_BITS-1:0]     warp_blue;
    logic [CH_BITS-1:0]     warp_green;
    logic [CH_BITS-1:0]     warp_red;
    logic [COLUMN_BITS-1:0] column;
  } in_word_t;

  typedef struct packed {
    logic [CH_BITS-1:0] out_blue;
    logic [CH_BITS-1:0] out_green;
    logic [CH_BITS-1:0] out_red;
    logic               in_overlap;
  } out_word_t;

  typedef struct packed {
    logic [CH_COUNT-1:0][CH_BITS-1:0] base;
    logic [CH_COUNT-1:0][CH_BITS-1:0] warp;
    logic                             overlap;
    logic                             blend;
    logic [WIDTH_BITS-1:0]            span;
    logic [WIDTH_BITS-1:0]            k;
    logic [WIDTH_BITS-1:0]            kc;
  } front_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] rem;
    logic [CH_BITS-1:0]    shf;
  } chan_div_t;

  typedef struct packed {
    logic [CH_COUNT-1:0][CH_BITS-1:0] base;
    logic                             overlap;
    logic                             blend;
    logic [WIDTH_BITS-1:0]            span;
    chan_div_t [CH_COUNT-1:0]         ch;
  } pipe_t;

endpackage

FILE: hdl/lsb_front.sv
// ----------------------------------------------------------------------------
// lsb_front
// Band check and weight setup: span, column offset and its complement.
// ----------------------------------------------------------------------------
module lsb_front import lsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COLUMN_BITS-1:0] start,
  input  logic [WIDTH_BITS-1:0]  width,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  in_word_t               up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output front_t                 dn_data
);

  logic   valid_r;
  front_t data_r;
  front_t data_nxt;

  always_comb begin
    logic [WIDTH_BITS-1:0] col_w;
    logic [WIDTH_BITS-1:0] start_w;
    col_w   = {1'b0, up_data.column};
    start_w = {1'b0, start};
    data_nxt.base    = {up_data.base_red, up_data.base_green, up_data.base_blue};
    data_nxt.warp    = {up_data.warp_red, up_data.warp_green, up_data.warp_blue};
    data_nxt.overlap = (up_data.column >= start) && (col_w < width);
    data_nxt.blend   = data_nxt.overlap &&
                       ((up_data.warp_blue | up_data.warp_green | up_data.warp_red) != '0);
    data_nxt.span    = width - start_w;
    data_nxt.k       = col_w - start_w;
    data_nxt.kc      = width - col_w;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hdl/lsb_mac.sv
// ----------------------------------------------------------------------------
// lsb_mac
// Weighted product sums per channel, split into divider remainder and bits.
// ----------------------------------------------------------------------------
module lsb_mac import lsb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  front_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output pipe_t  dn_data
);

  logic  valid_r;
  pipe_t data_r;
  pipe_t data_nxt;

  always_comb begin
    logic [SUM_BITS-1:0] sum;
    data_nxt.base    = up_data.base;
    data_nxt.overlap = up_data.overlap;
    data_nxt.blend   = up_data.blend;
    data_nxt.span    = up_data.span;
    for (int c = 0; c < CH_COUNT; c++) begin
      sum = SUM_BITS'(up_data.base[c]) * SUM_BITS'(up_data.kc)
          + SUM_BITS'(up_data.warp[c]) * SUM_BITS'(up_data.k);
      data_nxt.ch[c].rem = sum[SUM_BITS-1:CH_BITS];
      data_nxt.ch[c].shf = sum[CH_BITS-1:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hdl/lsb_cell.sv
// ----------------------------------------------------------------------------
// lsb_cell
// One restoring division step for all three channels: one quotient bit.
// ----------------------------------------------------------------------------
module lsb_cell import lsb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  pipe_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output pipe_t dn_data
);

  logic  valid_r;
  pipe_t data_r;
  pipe_t data_nxt;

  always_comb begin
    logic [WIDTH_BITS:0] trial;
    logic [WIDTH_BITS:0] diff;
    logic                ge;
    data_nxt = up_data;
    for (int c = 0; c < CH_COUNT; c++) begin
      trial = {up_data.ch[c].rem, up_data.ch[c].shf[CH_BITS-1]};
      diff  = trial - {1'b0, up_data.span};
      ge    = trial >= {1'b0, up_data.span};
      data_nxt.ch[c].rem = ge ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
      data_nxt.ch[c].shf = {up_data.ch[c].shf[CH_BITS-2:0], ge};
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hdl/linear_seam_blend_top.sv
// ----------------------------------------------------------------------------
// linear_seam_blend_top
// Linear feather blend of base and warped BGR pixels across an overlap band.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_ready  | in_word_t: base, warp, column
//   out_    | output    | out_valid/out_ready| out_word_t: blended BGR, in_overlap
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One word per cycle sustained while out_ready holds; the stages are band setup,
// product sum, then a chain of eight divider cells, one quotient bit per cell.
// Every stage has its own valid bit and takes a word when it is empty or its
// successor moves, so stalls back up stage by stage and bubbles close.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module linear_seam_blend_top import lsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [WIDTH_BITS-1:0] cfg_data
);

  logic [COLUMN_BITS-1:0] start_r;
  logic [WIDTH_BITS-1:0]  width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OVERLAP_START: start_r <= cfg_data[COLUMN_BITS-1:0];
        CFG_IMAGE_WIDTH:   width_r <= cfg_data;
      endcase
    end
  end

  logic   front_valid;
  logic   front_ready;
  front_t front_data;

  logic                valid_c [CELL_COUNT+1];
  logic                ready_c [CELL_COUNT+1];
  pipe_t               data_c  [CELL_COUNT+1];

  lsb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .width    (width_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_data  (front_data)
  );

  lsb_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (valid_c[0]),
    .dn_ready (ready_c[0]),
    .dn_data  (data_c[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    lsb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_c[i]),
      .up_ready (ready_c[i]),
      .up_data  (data_c[i]),
      .dn_valid (valid_c[i+1]),
      .dn_ready (ready_c[i+1]),
      .dn_data  (data_c[i+1])
    );
  end

  pipe_t last;

  assign last                 = data_c[CELL_COUNT];
  assign ready_c[CELL_COUNT]  = out_ready;
  assign out_valid            = valid_c[CELL_COUNT];
  assign out_data.out_blue    = last.blend ? last.ch[0].shf : last.base[0];
  assign out_data.out_green   = last.blend ? last.ch[1].shf : last.base[1];
  assign out_data.out_red     = last.blend ? last.ch[2].shf : last.base[2];
  assign out_data.in_overlap  = last.overlap;

endmodule
